[rtl/sli_pkg.sv]
// Package: sizes, codes, state and control types of the sequential list unit.
`default_nettype none
package sli_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture request beat
    logic exec;   // apply operation, load result register
  } cmd_t;

endpackage
`default_nettype wire

[rtl/sli_req_if.sv]
// Interface: request channel (operation, position, value).
`default_nettype none
interface sli_req_if;
  import sli_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface
`default_nettype wire

[rtl/sli_rsp_if.sv]
// Interface: result channel (status, data, count, flags).
`default_nettype none
interface sli_rsp_if;
  import sli_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data;
  logic [CNT_W-1:0]         count;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, output status, output data, output count,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input data, input count,
                  input is_empty, input is_full, output ready);
endinterface
`default_nettype wire

[rtl/sli_ctrl.sv]
// Controller: two-state sequencer and result-valid register.
`default_nettype none
module sli_ctrl
  import sli_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd.load       = 1'b0;
    cmd.exec       = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait until the result register is free or drains this cycle
        if (!out_valid || out_ready) begin
          cmd.exec       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_load_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_EXEC)
    else $error("accepted beat not followed by execute");
  a_exec_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid && state == S_IDLE)
    else $error("execute did not present a result");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !out_valid || out_ready)
    else $error("result overwritten before taken");
`endif

endmodule
`default_nettype wire

[rtl/sli_datapath.sv]
// Datapath: element registers, length, request latch and result register.
`default_nettype none
module sli_datapath
  import sli_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cmd_t                     cmd,
  input  wire logic [1:0]               in_operation,
  input  wire logic [POS_W-1:0]         in_position,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic [1:0]                    out_status,
  output logic signed [DATA_W-1:0]      out_data,
  output logic [CNT_W-1:0]              out_count,
  output logic                          out_is_empty,
  output logic                          out_is_full
);

  logic [DATA_W-1:0] elements      [CAPACITY];
  logic [DATA_W-1:0] elements_next [CAPACITY];
  logic [CNT_W-1:0]  used, used_next;

  logic [1:0]        op_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;

  logic [1:0]        status_next;
  logic [DATA_W-1:0] data_next;
  logic              shift_ins, shift_del;
  logic [POS_W:0]    pos_ext, used_ext;
  logic [POS_W-1:0]  pos_m1;
  logic [IDX_W-1:0]  idx;
  logic              rd_ok, ins_ok, full_now;

  always_comb begin
    pos_ext  = {1'b0, pos_q};
    used_ext = (POS_W + 1)'(used);
    pos_m1   = pos_q - POS_W'(1);
    idx      = pos_m1[IDX_W-1:0];
    full_now = (used == CNT_W'(CAPACITY));
    rd_ok    = (pos_q != '0) && (pos_ext <= used_ext);
    ins_ok   = (pos_q != '0) && (pos_ext <= used_ext + (POS_W + 1)'(1));

    status_next = ST_RANGE;
    data_next   = '0;
    used_next   = used;
    shift_ins   = 1'b0;
    shift_del   = 1'b0;
    case (op_q)
      OP_INSERT: begin
        if (full_now) begin
          status_next = ST_FULL;
        end else if (ins_ok) begin
          status_next = ST_OK;
          shift_ins   = 1'b1;
          used_next   = used + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (used == '0) begin
          status_next = ST_EMPTY;
        end else if (rd_ok) begin
          status_next = ST_OK;
          data_next   = elements[idx];
          shift_del   = 1'b1;
          used_next   = used - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (rd_ok) begin
          status_next = ST_OK;
          data_next   = elements[idx];
        end
      end
      default: begin
        status_next = ST_RANGE;
      end
    endcase
  end

  // each slot picks itself, the inserted value, its lower or its upper neighbor
  for (genvar k = 0; k < CAPACITY; k++) begin : g_slot
    always_comb begin
      elements_next[k] = elements[k];
      if (shift_ins) begin
        if (IDX_W'(k) == idx) begin
          elements_next[k] = val_q;
        end else if ((IDX_W'(k) > idx) && (CNT_W'(k) <= used)) begin
          if (k > 0) begin
            elements_next[k] = elements[(k > 0) ? k - 1 : 0];
          end
        end
      end else if (shift_del) begin
        if ((IDX_W'(k) >= idx) && (CNT_W'(k + 1) < used)) begin
          if (k < CAPACITY - 1) begin
            elements_next[k] = elements[(k < CAPACITY - 1) ? k + 1 : k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_operation;
      pos_q <= in_position;
      val_q <= in_value;
    end
    if (cmd.exec) begin
      out_status   <= status_next;
      out_data     <= data_next;
      out_count    <= used_next;
      out_is_empty <= (used_next == '0);
      out_is_full  <= (used_next == CNT_W'(CAPACITY));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        elements[i] <= '0;
      end
    end else if (cmd.exec) begin
      used <= used_next;
      for (int i = 0; i < CAPACITY; i++) begin
        elements[i] <= elements_next[i];
      end
    end
  end

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(CAPACITY))
    else $error("length beyond capacity");
  a_used_step: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> used == $past(used))
    else $error("length changed without execute");
`endif

endmodule
`default_nettype wire

[rtl/sequential_list_insert_delete_unit.sv]
// Top level: sequential list unit with insert, delete and read.
//
// Keeps an ordered list of up to CAPACITY (16) signed 32-bit values in
// registers. A request beat on req carries operation (insert, delete,
// read), a 1-based position and a value for insert. Each request gives
// exactly one result beat on rsp with status, data, the length after the
// operation and the empty and full flags.
//
// Order: an accepted request is first latched, then in the execute state
// all slots shift at once and the result register loads. One request is
// in work at a time, so the next request is taken only after the current
// one has loaded its result register.
//
// The result register decouples the channels: a new request is taken
// while an earlier result still waits. If rsp stalls, the next operation
// holds in its execute state until the pending result is taken.
//
// Reset (rst, synchronous): list cleared to zeros, length 0, no result
// pending, req ready as soon as rst is low.
`default_nettype none
module sequential_list_insert_delete_unit
  import sli_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  sli_req_if.sink   req,
  sli_rsp_if.source rsp
);

  cmd_t cmd;

  sli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  sli_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_operation (req.operation),
    .in_position  (req.position),
    .in_value     (req.value),
    .out_status   (rsp.status),
    .out_data     (rsp.data),
    .out_count    (rsp.count),
    .out_is_empty (rsp.is_empty),
    .out_is_full  (rsp.is_full)
  );

endmodule
`default_nettype wire
